/* design/assert_macros.svh */
// Assertion macros shared by the gauge RTL.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset
`define BLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every clock edge, reset included
`define BLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* design/ble_pkg.sv */
// Types and constants of the trimmed-mean battery gauge.
// No dependencies.
package ble_pkg;

  localparam int unsigned NUM_SAMPLES = 10;
  localparam int unsigned SORT_W      = 8;
  localparam int unsigned SUM_W       = 13;
  localparam int unsigned DVD_W       = 22;
  localparam int unsigned DVR_W       = 15;
  localparam int unsigned MV_W        = 15;
  localparam int unsigned PCT_W       = 7;

  // Register indexes
  localparam logic [1:0] REG_MV_PER_COUNT = 2'd0;
  localparam logic [1:0] REG_EMPTY_MV     = 2'd1;
  localparam logic [1:0] REG_SPAN_MV      = 2'd2;
  localparam logic [1:0] REG_MIN_INTERVAL = 2'd3;

  // Register reset values
  localparam logic [15:0] MV_PER_COUNT_RST = 16'd22257;
  localparam logic [14:0] EMPTY_MV_RST     = 15'd10500;
  localparam logic [14:0] SPAN_MV_RST      = 15'd2000;
  localparam logic [31:0] MIN_INTERVAL_RST = 32'd1000000;

  localparam logic [14:0] MV_MAX      = 15'h7FFF;
  localparam logic [6:0]  PCT_FULL    = 7'd100;

  typedef struct packed {
    logic [7:0]  sample_0;
    logic [7:0]  sample_1;
    logic [7:0]  sample_2;
    logic [7:0]  sample_3;
    logic [7:0]  sample_4;
    logic [7:0]  sample_5;
    logic [7:0]  sample_6;
    logic [7:0]  sample_7;
    logic [7:0]  sample_8;
    logic [7:0]  sample_9;
    logic [63:0] now_us;
  } ble_in_t;

  typedef struct packed {
    logic        accepted;
    logic [14:0] battery_mv;
    logic [6:0]  percent;
    logic        have_reading;
  } ble_out_t;

  // Control of the sorting chain
  typedef struct packed {
    logic clear;
    logic shift;
  } ble_ctrl_t;

endpackage

/* design/ble_cell.sv */
// One cell of the insertion sorting chain: keeps the smaller word, hands on the larger.
// Depends on ble_pkg.
module ble_cell import ble_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ble_ctrl_t         ctrl_i,
  input  logic              in_v_i,
  input  logic [SORT_W-1:0] in_d_i,
  input  logic              right_v_i,
  input  logic [SORT_W-1:0] right_d_i,
  output logic              hold_v_o,
  output logic [SORT_W-1:0] hold_d_o,
  output logic              pass_v_o,
  output logic [SORT_W-1:0] pass_d_o
);

  logic              hold_v_q, pass_v_q;
  logic [SORT_W-1:0] hold_d_q, pass_d_q;

  // Insert, shift towards the head, or clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      pass_v_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      hold_v_q <= 1'b0;
      pass_v_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      hold_v_q <= right_v_i;
      pass_v_q <= 1'b0;
    end else begin
      pass_v_q <= in_v_i && hold_v_q;
      if (in_v_i) hold_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      hold_d_q <= right_d_i;
    end else if (in_v_i) begin
      if (!hold_v_q) begin
        hold_d_q <= in_d_i;
      end else if (in_d_i < hold_d_q) begin
        hold_d_q <= in_d_i;
        pass_d_q <= hold_d_q;
      end else begin
        pass_d_q <= in_d_i;
      end
    end
  end

  assign hold_v_o = hold_v_q;
  assign hold_d_o = hold_d_q;
  assign pass_v_o = pass_v_q;
  assign pass_d_o = pass_d_q;

endmodule

/* design/ble_chain.sv */
// Row of sorting cells; words enter at the head and leave smallest first.
// Depends on ble_pkg and ble_cell.
module ble_chain import ble_pkg::*; #(
  parameter int unsigned NUM_CELLS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ble_ctrl_t         ctrl_i,
  input  logic              feed_v_i,
  input  logic [SORT_W-1:0] feed_d_i,
  output logic [SORT_W-1:0] head_d_o
);

  logic              hold_v [NUM_CELLS];
  logic [SORT_W-1:0] hold_d [NUM_CELLS];
  logic              pass_v [NUM_CELLS];
  logic [SORT_W-1:0] pass_d [NUM_CELLS];

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic              in_v, right_v;
    logic [SORT_W-1:0] in_d, right_d;
    if (i == 0) begin : g_head
      assign in_v = feed_v_i;
      assign in_d = feed_d_i;
    end else begin : g_body
      assign in_v = pass_v[i-1];
      assign in_d = pass_d[i-1];
    end
    if (i == NUM_CELLS - 1) begin : g_tail
      assign right_v = 1'b0;
      assign right_d = '0;
    end else begin : g_mid
      assign right_v = hold_v[i+1];
      assign right_d = hold_d[i+1];
    end
    ble_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl_i),
      .in_v_i    (in_v),
      .in_d_i    (in_d),
      .right_v_i (right_v),
      .right_d_i (right_d),
      .hold_v_o  (hold_v[i]),
      .hold_d_o  (hold_d[i]),
      .pass_v_o  (pass_v[i]),
      .pass_d_o  (pass_d[i])
    );
  end

  assign head_d_o = hold_d[0];

endmodule

/* design/ble_div.sv */
// Restoring divider, one quotient bit a cycle.
// Depends on ble_pkg.
module ble_div import ble_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVR_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DVD_W-1:0] num_q;
  logic [DVR_W-1:0] den_q;
  logic [DVR_W-1:0] rem_q;
  logic [DVR_W:0]   shifted;
  logic [DVR_W+1:0] diff;

  assign shifted = {rem_q, num_q[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};

  // Count down the quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (start_i) cnt_q <= CNT_W'(DVD_W);
      else if (cnt_q != '0) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // Trial subtract and shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[DVD_W-2:0], ~diff[DVR_W+1]};
      rem_q <= diff[DVR_W+1] ? shifted[DVR_W-1:0] : diff[DVR_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

/* design/battery_level_estimator_top.sv */
// Top level of the trimmed-mean battery gauge: control, registers, history.
// Depends on ble_pkg, ble_chain, ble_div and assert_macros.svh.
//
// channel | direction | handshake           | word
// in      | in        | in_valid_i/stall_o  | ble_in_t (ten samples, time)
// out     | out       | out_valid_o/stall_i | ble_out_t (flag, mV, percent)
// cfg     | in        | cfg_valid_i/ready_o | index 0..3, 32-bit data
//
// One word at a time: a new batch is taken only once the last is finished. An
// accepted batch runs the cell row's fill, drain and shift over its samples, the
// percent divide (skipped at or below empty or with zero span), then the same over
// the history and its mean divide; a rate-limited one runs only the history part.
// Reset clears all control and sets the registers to their defaults.
// The result waits in its register while out_stall_i is high; a following
// batch is taken but its result waits until the register is free.
module battery_level_estimator_top import ble_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 16,
  parameter int unsigned BATCH_SIZE    = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  ble_in_t    in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output ble_out_t   out_word_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned NUM_CELLS = (HISTORY_DEPTH > BATCH_SIZE) ? HISTORY_DEPTH : BATCH_SIZE;
  localparam int unsigned KW = $clog2(NUM_CELLS + 3);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned SW = $clog2(NUM_SAMPLES);
  localparam int unsigned PW = CW + 12;

  // Kept samples of a batch and the rounded-up reciprocal that averages them
  localparam int unsigned TRIM_N   = BATCH_SIZE - 4;
  localparam int unsigned RECIP_SH = 14;
  localparam int unsigned RECIP    = ((1 << RECIP_SH) + TRIM_N - 1) / TRIM_N;
  localparam int unsigned AVW      = SUM_W + RECIP_SH + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FEED  = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_DIVB  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_PCT   = 4'd6;
  localparam logic [3:0] S_DIVP  = 4'd7;
  localparam logic [3:0] S_STORE = 4'd8;
  localparam logic [3:0] S_HSET  = 4'd9;
  localparam logic [3:0] S_HDIV  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  // Configuration registers
  logic [15:0] mv_per_count_q;
  logic [14:0] empty_mv_q, span_mv_q;
  logic [31:0] min_interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_per_count_q <= MV_PER_COUNT_RST;
      empty_mv_q     <= EMPTY_MV_RST;
      span_mv_q      <= SPAN_MV_RST;
      min_interval_q <= MIN_INTERVAL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MV_PER_COUNT: mv_per_count_q <= cfg_data_i[15:0];
        REG_EMPTY_MV:     empty_mv_q     <= cfg_data_i[14:0];
        REG_SPAN_MV:      span_mv_q      <= cfg_data_i[14:0];
        REG_MIN_INTERVAL: min_interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Control state
  logic [3:0]    state_q;
  logic [KW-1:0] k_q;
  logic          hist_q, acc_flag_q, filling_q, feed_v_q, div_start_q, out_valid_q;
  logic [AW-1:0] wi_q;
  logic [CW-1:0] cnt_q;
  logic [63:0]   last_q, now_q;
  logic [14:0]   volt_q, mv_q;
  logic [6:0]    pct_q, mean_q;
  logic [7:0]    avg_q;
  logic [SUM_W-1:0] sum_q;
  logic [SORT_W-1:0] feed_d_q;
  logic [SORT_W-1:0] smp_q [NUM_SAMPLES];
  logic [PCT_W-1:0]  mem_q [HISTORY_DEPTH];
  ble_out_t out_q;

  // Datapath helpers
  logic [SORT_W-1:0] head_d;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo, div_dvd;
  logic [DVR_W-1:0]  div_dvr;
  logic [KW-1:0]     n_w, lo_w, hi_w;
  logic [PW-1:0]     skip_prod;
  logic [CW-1:0]     skip;
  logic [63:0]       elapsed;
  logic              in_take, take_batch;
  logic [23:0]       prod;
  logic [14:0]       mv_diff;
  logic [AVW-1:0]    avg_prod;
  ble_ctrl_t         ctrl;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign elapsed    = in_word_i.now_us - last_q;
  assign take_batch = filling_q || (elapsed > {32'd0, min_interval_q});

  // Lowest tenth of the held entries: count*205 >> 11 equals count/10 here
  assign skip_prod = PW'(cnt_q) * PW'(205);
  assign skip      = CW'(skip_prod >> 11);

  assign n_w  = hist_q ? KW'(cnt_q) : KW'(BATCH_SIZE);
  assign lo_w = hist_q ? KW'(skip) : KW'(2);
  assign hi_w = hist_q ? KW'(cnt_q) : KW'(BATCH_SIZE - 2);

  // Batch average: the sum times the reciprocal, exact for every reachable sum
  assign avg_prod = AVW'(sum_q) * AVW'(RECIP);

  assign prod    = 24'(avg_q) * 24'(mv_per_count_q);
  assign mv_diff = mv_q - empty_mv_q;

  assign ctrl.clear = (state_q == S_IDLE) || (state_q == S_HSET);
  assign ctrl.shift = (state_q == S_SHIFT);

  // Divider operands by phase
  always_comb begin
    div_dvd = '0;
    div_dvr = DVR_W'(1);
    case (state_q)
      S_DIVP: begin
        div_dvd = DVD_W'(mv_diff) * DVD_W'(100);
        div_dvr = span_mv_q;
      end
      S_HDIV: begin
        div_dvd = DVD_W'(sum_q);
        div_dvr = DVR_W'(cnt_q - skip);
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      hist_q      <= 1'b0;
      acc_flag_q  <= 1'b0;
      filling_q   <= 1'b1;
      wi_q        <= '0;
      cnt_q       <= '0;
      last_q      <= '0;
      volt_q      <= '0;
      feed_v_q    <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_take) begin
            acc_flag_q <= take_batch;
            k_q        <= '0;
            hist_q     <= 1'b0;
            state_q    <= take_batch ? S_FEED : S_HSET;
          end
        end
        S_FEED: begin
          if (k_q < n_w) begin
            feed_v_q <= 1'b1;
            k_q      <= k_q + KW'(1);
          end else begin
            feed_v_q <= 1'b0;
            k_q      <= '0;
            state_q  <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (k_q == KW'(NUM_CELLS + 1)) begin
            k_q     <= '0;
            state_q <= S_SHIFT;
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        S_SHIFT: begin
          if (k_q + KW'(1) >= n_w) begin
            div_start_q <= hist_q;
            state_q     <= hist_q ? S_HDIV : S_DIVB;
          end
          k_q <= k_q + KW'(1);
        end
        S_DIVB: state_q <= S_MUL;
        S_MUL: state_q <= S_PCT;
        S_PCT: begin
          if (mv_q <= empty_mv_q || span_mv_q == '0) begin
            state_q <= S_STORE;
          end else begin
            div_start_q <= 1'b1;
            state_q     <= S_DIVP;
          end
        end
        S_DIVP: begin
          if (div_done) state_q <= S_STORE;
        end
        S_STORE: begin
          volt_q <= mv_q;
          last_q <= now_q;
          if (wi_q == AW'(HISTORY_DEPTH - 1)) begin
            wi_q      <= '0;
            filling_q <= 1'b0;
          end else begin
            wi_q <= wi_q + AW'(1);
          end
          state_q <= S_HSET;
        end
        S_HSET: begin
          cnt_q   <= filling_q ? CW'(wi_q) : CW'(HISTORY_DEPTH);
          hist_q  <= 1'b1;
          k_q     <= '0;
          state_q <= S_FEED;
        end
        S_HDIV: begin
          if (cnt_q == '0 || div_done) state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload: samples, history store, sums and results
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      smp_q[0] <= in_word_i.sample_0;
      smp_q[1] <= in_word_i.sample_1;
      smp_q[2] <= in_word_i.sample_2;
      smp_q[3] <= in_word_i.sample_3;
      smp_q[4] <= in_word_i.sample_4;
      smp_q[5] <= in_word_i.sample_5;
      smp_q[6] <= in_word_i.sample_6;
      smp_q[7] <= in_word_i.sample_7;
      smp_q[8] <= in_word_i.sample_8;
      smp_q[9] <= in_word_i.sample_9;
      now_q    <= in_word_i.now_us;
    end
    if (state_q == S_FEED && k_q < n_w) begin
      feed_d_q <= hist_q ? {1'b0, mem_q[k_q[AW-1:0]]} : smp_q[k_q[SW-1:0]];
    end
    if (state_q == S_DRAIN) sum_q <= '0;
    if (state_q == S_SHIFT && k_q >= lo_w && k_q < hi_w) begin
      sum_q <= sum_q + SUM_W'(head_d);
    end
    if (state_q == S_DIVB) avg_q <= avg_prod[RECIP_SH +: 8];
    if (state_q == S_MUL) mv_q <= (prod[23] == 1'b1) ? MV_MAX : prod[22:8];
    if (state_q == S_PCT) pct_q <= (mv_q <= empty_mv_q) ? '0 : PCT_FULL;
    if (state_q == S_DIVP && div_done) begin
      pct_q <= (div_quo > DVD_W'(PCT_FULL)) ? PCT_FULL : div_quo[6:0];
    end
    if (state_q == S_STORE) mem_q[wi_q] <= pct_q;
    if (state_q == S_HDIV) mean_q <= (cnt_q == '0) ? '0 : div_quo[6:0];
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      out_q.accepted     <= acc_flag_q;
      out_q.battery_mv   <= volt_q;
      out_q.percent      <= mean_q;
      out_q.have_reading <= !(filling_q && wi_q == '0);
    end
  end

  ble_chain #(.NUM_CELLS(NUM_CELLS)) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .feed_v_i (feed_v_q),
    .feed_d_i (feed_d_q),
    .head_d_o (head_d)
  );

  ble_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvr),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `include "assert_macros.svh"

  `BLE_ASSERT_ALWAYS(a_wi_range, wi_q <= AW'(HISTORY_DEPTH - 1), "write index past depth")
  `BLE_ASSERT(a_pct_range, out_valid_o |-> out_word_o.percent <= PCT_FULL, "percent above 100")
  `BLE_ASSERT(a_have, (out_valid_o && !out_word_o.have_reading) |-> filling_q, "no reading but full")
  `BLE_ASSERT(a_busy_stall, (state_q != S_IDLE) |-> in_stall_o, "input taken while busy")

endmodule

/* tb/sv/tb_battery_level_estimator_checker.sv */
// Checker of the battery gauge: watches the register, batch and status channels,
// predicts each status word and compares it with the block's. Depends on ble_pkg.
module tb_battery_level_estimator_checker import ble_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  ble_in_t     in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  ble_out_t    out_word_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 16;

  // Own copy of the registers
  logic [15:0] mv_per_count;
  logic [14:0] empty_mv;
  logic [14:0] span_mv;
  logic [31:0] min_interval;

  // Own copy of the gauge state
  logic [6:0]  pct_hist [DEPTH];
  int unsigned wr_idx;
  bit          still_filling;
  logic [63:0] last_upd_us;
  logic [14:0] stored_mv;

  ble_out_t status_q [$];

  assign pending_o = status_q.size();

  // Insertion sort of the first n values
  function automatic void sort_vals(ref int unsigned a [DEPTH], input int unsigned n);
    int unsigned v;
    int j;
    for (int i = 1; i < n; i++) begin
      v = a[i];
      j = i;
      while (j > 0 && a[j-1] > v) begin
        a[j] = a[j-1];
        j--;
      end
      a[j] = v;
    end
  endfunction

  // Advance the gauge by one batch and return the status it reports
  function automatic ble_out_t gauge_step(ble_in_t w);
    int unsigned vals [DEPTH];
    int unsigned tot, avg, mv, pc, cnt, skip;
    logic [63:0] dt;
    bit take;
    ble_out_t r;
    dt   = w.now_us - last_upd_us;
    take = still_filling || (dt > {32'd0, min_interval});
    if (take) begin
      foreach (vals[i]) vals[i] = 0;
      vals[0] = w.sample_0; vals[1] = w.sample_1; vals[2] = w.sample_2;
      vals[3] = w.sample_3; vals[4] = w.sample_4; vals[5] = w.sample_5;
      vals[6] = w.sample_6; vals[7] = w.sample_7; vals[8] = w.sample_8;
      vals[9] = w.sample_9;
      sort_vals(vals, 10);
      tot = 0;
      for (int i = 2; i < 8; i++) tot += vals[i];
      avg = tot / 6;
      mv  = (avg * mv_per_count) >> 8;
      stored_mv = (mv > 32767) ? 15'h7FFF : mv[14:0];
      // Percentage of the stored voltage, capped at full
      if (stored_mv <= empty_mv) pc = 0;
      else if (span_mv == 0) pc = 100;
      else begin
        pc = ((stored_mv - empty_mv) * 100) / span_mv;
        if (pc > 100) pc = 100;
      end
      pct_hist[wr_idx] = pc[6:0];
      wr_idx++;
      if (wr_idx >= DEPTH) begin
        wr_idx = 0;
        still_filling = 1'b0;
      end
      last_upd_us = w.now_us;
    end
    // Trimmed mean of the held entries, lowest tenth dropped
    cnt = still_filling ? wr_idx : DEPTH;
    r.percent = '0;
    if (cnt != 0) begin
      for (int i = 0; i < DEPTH; i++) vals[i] = (i < cnt) ? pct_hist[i] : 0;
      sort_vals(vals, cnt);
      skip = cnt / 10;
      tot = 0;
      for (int i = skip; i < cnt; i++) tot += vals[i];
      r.percent = 7'(tot / (cnt - skip));
    end
    r.accepted     = take;
    r.battery_mv   = stored_mv;
    r.have_reading = !(still_filling && wr_idx == 0);
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    ble_out_t exp_w;
    if (!rst_ni) begin
      mv_per_count  <= MV_PER_COUNT_RST;
      empty_mv      <= EMPTY_MV_RST;
      span_mv       <= SPAN_MV_RST;
      min_interval  <= MIN_INTERVAL_RST;
      foreach (pct_hist[i]) pct_hist[i] = '0;
      wr_idx        = 0;
      still_filling = 1'b1;
      last_upd_us   = '0;
      stored_mv     = '0;
      status_q.delete();
      errors_o      <= 0;
    end else begin
      // Track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MV_PER_COUNT: mv_per_count <= cfg_data_i[15:0];
          REG_EMPTY_MV:     empty_mv     <= cfg_data_i[14:0];
          REG_SPAN_MV:      span_mv      <= cfg_data_i[14:0];
          REG_MIN_INTERVAL: min_interval <= cfg_data_i;
          default: ;
        endcase
      end
      // Predict on every accepted batch word
      if (in_valid_i && !in_stall_i) status_q.push_back(gauge_step(in_word_i));
      // Compare every accepted status word with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (status_q.size() == 0) begin
          $error("status word with nothing expected: %p", out_word_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_w = status_q.pop_front();
          if (out_word_i !== exp_w) begin
            errors_o <= errors_o + 1;
            if (out_word_i.accepted !== exp_w.accepted)
              $error("accepted: expected %0d, got %0d", exp_w.accepted, out_word_i.accepted);
            if (out_word_i.battery_mv !== exp_w.battery_mv)
              $error("battery_mv: expected %0d, got %0d",
                     exp_w.battery_mv, out_word_i.battery_mv);
            if (out_word_i.percent !== exp_w.percent)
              $error("percent: expected %0d, got %0d", exp_w.percent, out_word_i.percent);
            if (out_word_i.have_reading !== exp_w.have_reading)
              $error("have_reading: expected %0d, got %0d",
                     exp_w.have_reading, out_word_i.have_reading);
          end
        end
      end
    end
  end

endmodule

/* tb/sv/tb_battery_level_estimator_top.sv */
// Testbench top of the battery gauge: clock, reset, batch and register stimulus,
// random stalls and the verdict. Depends on ble_pkg and the checker module.
module tb_battery_level_estimator_top import ble_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 400;
  localparam int IDLE_LIMIT    = 6000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  ble_in_t     in_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  ble_out_t    out_word_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  int          errors;
  int          pending;
  int          idle_cnt;
  int          stall_left;
  bit          quiet;
  logic [63:0] now_t;
  logic [31:0] cur_interval;

  battery_level_estimator_top dut (.*);

  tb_battery_level_estimator_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_word_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  // Clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Random stalls on the status channel, bursts mostly short
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 3);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("FAIL battery_level_estimator_top");
      $finish;
    end
  end

  // Random gap before a word, mostly short
  function automatic int pick_gap();
    if (quiet) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // Send one batch word and hold it until taken
  task automatic send_batch(ble_in_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  // Write one register
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drain the block, then write all four registers
  task automatic set_regs(logic [15:0] mvq, logic [14:0] emp, logic [14:0] spn,
                          logic [31:0] ivl);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_MV_PER_COUNT, {16'd0, mvq});
    write_reg(REG_EMPTY_MV, {17'd0, emp});
    write_reg(REG_SPAN_MV, {17'd0, spn});
    write_reg(REG_MIN_INTERVAL, ivl);
    cur_interval = ivl;
  endtask

  function automatic ble_in_t make_word(logic [79:0] s, logic [63:0] t);
    ble_in_t w;
    {w.sample_0, w.sample_1, w.sample_2, w.sample_3, w.sample_4,
     w.sample_5, w.sample_6, w.sample_7, w.sample_8, w.sample_9} = s;
    w.now_us = t;
    return w;
  endfunction

  // Samples: clustered around a level, each with a one-in-four chance of being fully random
  function automatic logic [79:0] rand_samples();
    logic [79:0] s;
    int base;
    base = $urandom_range(0, 255);
    for (int i = 0; i < 10; i++) begin
      if ($urandom_range(0, 3) == 0) s[i*8 +: 8] = 8'($urandom);
      else s[i*8 +: 8] = 8'(base + $urandom_range(0, 6) - 3);
    end
    return s;
  endfunction

  // Advance the clock value: often just past the interval, else at it, early, backwards or random
  function automatic logic [63:0] next_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      now_t = now_t + cur_interval + 1 + $urandom_range(0, 3);
    else if (r < 55) now_t = now_t + cur_interval;
    else if (r < 75) now_t = now_t + $urandom_range(0, 1000);
    else if (r < 85) now_t = now_t + cur_interval - $urandom_range(0, 50);
    else if (r < 92) now_t = now_t - $urandom_range(1, 100);
    else             now_t = {$urandom, $urandom};
    return now_t;
  endfunction

  initial begin
    logic [63:0] t;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    out_stall_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    idle_cnt     = 0;
    stall_left   = 0;
    quiet        = 1'b0;
    now_t        = 64'd0;
    cur_interval = MIN_INTERVAL_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: filling history at reset settings, extremes of the samples
    send_batch(make_word({10{8'h00}}, 64'd0));
    send_batch(make_word({10{8'hFF}}, 64'd5));
    send_batch(make_word({8'hFF, 8'hFF, {6{8'h80}}, 8'h00, 8'h00}, 64'd3));
    send_batch(make_word({8'h00, 8'h01, 8'h02, 8'h03, 8'h04,
                          8'h05, 8'h06, 8'h07, 8'h08, 8'h09}, 64'hFFFF_FFFF_FFFF_FFFF));
    send_batch(make_word({8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA,
                          8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55}, 64'hAAAA_5555_AAAA_5555));
    send_batch(make_word({8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
                          8'hAA, 8'hAA, 8'h55, 8'h55, 8'hAA}, 64'h5555_AAAA_5555_AAAA));
    for (int i = 0; i < 12; i++) send_batch(make_word(rand_samples(), 64'd10 + i));
    // Past filling: a gap beyond the interval is taken, the next is too early, stepping back wraps
    now_t = 64'd100;
    send_batch(make_word(rand_samples(), now_t + MIN_INTERVAL_RST));
    send_batch(make_word(rand_samples(), now_t + MIN_INTERVAL_RST + 1));
    send_batch(make_word(rand_samples(), 64'd50));

    // Zero span with empty near mid range
    set_regs(16'hFFFF, 15'd16000, 15'd0, 32'd0);
    send_batch(make_word({10{8'hFF}}, 64'd60));
    send_batch(make_word({10{8'h00}}, 64'd60));
    send_batch(make_word({10{8'h40}}, 64'd61));
    now_t = 64'd61;

    // Random phases over several settings, extremes first
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_regs(16'hFFFF, 15'h7FFF, 15'h7FFF, 32'hFFFF_FFFF);
        1: set_regs(16'h0000, 15'h0000, 15'd1, 32'd0);
        2: set_regs(MV_PER_COUNT_RST, EMPTY_MV_RST, SPAN_MV_RST, MIN_INTERVAL_RST);
        3: set_regs(16'hFFFF, 15'd0, 15'd1, 32'd1);
        default: set_regs(16'($urandom), 15'($urandom_range(0, 20000)),
                          15'($urandom_range(1, 32767)), $urandom_range(0, 5000000));
      endcase
      quiet = (ph % 3 == 2);
      for (int i = 0; i < 125; i++) begin
        t = next_time();
        send_batch(make_word(rand_samples(), t));
      end
    end

    // Wait for the last status words
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0)
      $display("PASS battery_level_estimator_top");
    else
      $display("FAIL battery_level_estimator_top");
    $finish;
  end

endmodule
